// File: rtl/tkps_pkg.sv
// Package for the top-k priority selector: sizes, entry type, control structs
// and the ranking function used by the cells and the top level.
// Depends on nothing.
`timescale 1ns / 1ps

package tkps_pkg;

    localparam int CAPACITY   = 4;
    localparam int MAX_RADIUS = 1023;

    localparam int COORD_W    = 32;
    localparam int OFS_W      = 11;
    localparam int OUT_DIST_W = 21;
    // Wide enough to hold any offset and any radius as a signed value.
    localparam int WIDE_W     = 17;

    // An 11-bit offset never exceeds 1024 in magnitude, whatever the radius.
    localparam int MAG_MAX = (MAX_RADIUS < 1024) ? MAX_RADIUS : 1024;
    localparam int MAG_W   = $clog2(MAG_MAX + 1);
    localparam int DIST_W  = $clog2(2 * MAG_MAX * MAG_MAX + 1);

    typedef enum logic
    {
        OP_OFFER = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    typedef enum logic
    {
        ST_COLLECT,
        ST_DRAIN
    } state_t;

    typedef struct packed
    {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               vis;
        logic [DIST_W-1:0]  dist_sq;
    } entry_t;

    typedef struct packed
    {
        logic   valid;
        op_t    op;
        entry_t entry;
    } stage_t;

    typedef struct packed
    {
        logic offer;
        logic shift;
    } cell_ctrl_t;

    // True when candidate a ranks strictly ahead of entry b.
    function automatic logic beats(entry_t a, entry_t b);
        logic result;
        if (a.vis != b.vis)
        begin
            result = a.vis;
        end
        else
        begin
            result = (a.dist_sq < b.dist_sq);
        end
        return result;
    endfunction

    // Magnitude of an offset after clamping it to the radius.
    function automatic logic [MAG_W-1:0] offset_mag(logic signed [OFS_W-1:0] ofs);
        logic signed [WIDE_W-1:0] wide;
        logic        [WIDE_W-1:0] mag;
        wide = WIDE_W'(ofs);
        if (wide < 0)
        begin
            mag = WIDE_W'(-wide);
        end
        else
        begin
            mag = WIDE_W'(wide);
        end
        if (mag > WIDE_W'(MAX_RADIUS))
        begin
            mag = WIDE_W'(MAX_RADIUS);
        end
        return mag[MAG_W-1:0];
    endfunction

endpackage

// File: rtl/tkps_if.sv
// Valid/ready channel interfaces for the candidate input and the result output.
// Depends on tkps_pkg.
`timescale 1ns / 1ps

interface tkps_in_if;
    logic                                  valid;
    logic                                  ready;
    tkps_pkg::op_t                         operation;
    logic signed [tkps_pkg::COORD_W-1:0]   pos_x;
    logic signed [tkps_pkg::COORD_W-1:0]   pos_y;
    logic signed [tkps_pkg::OFS_W-1:0]     offset_x;
    logic signed [tkps_pkg::OFS_W-1:0]     offset_y;
    logic                                  visible;

    modport source (output valid, operation, pos_x, pos_y, offset_x, offset_y, visible,
                    input ready);
    modport sink   (input valid, operation, pos_x, pos_y, offset_x, offset_y, visible,
                    output ready);
endinterface

interface tkps_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [tkps_pkg::COORD_W-1:0]   out_x;
    logic signed [tkps_pkg::COORD_W-1:0]   out_y;
    logic                                  out_visible;
    logic        [tkps_pkg::OUT_DIST_W-1:0] out_dist_sq;
    logic                                  last;

    modport source (output valid, out_x, out_y, out_visible, out_dist_sq, last,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_visible, out_dist_sq, last,
                    output ready);
endinterface

// File: rtl/tkps_dist.sv
// Input stage: clamps the offsets, squares them and registers the candidate
// with its distance. Depends on tkps_pkg and tkps_if.
`timescale 1ns / 1ps

module tkps_dist
(
    input  logic              clk,
    input  logic              rst_n,
    tkps_in_if.sink           req,
    input  logic              hold,
    output tkps_pkg::stage_t  stage
);

    logic                          valid_reg;
    logic                          valid_next;
    tkps_pkg::op_t                 op_reg;
    tkps_pkg::entry_t              entry_reg;
    logic [tkps_pkg::MAG_W-1:0]    mag_x;
    logic [tkps_pkg::MAG_W-1:0]    mag_y;
    logic [2*tkps_pkg::MAG_W-1:0]  sq_x;
    logic [2*tkps_pkg::MAG_W-1:0]  sq_y;
    logic [tkps_pkg::DIST_W-1:0]   dist_sq;
    logic                          accept;

    assign req.ready = !hold;
    assign accept    = req.valid && req.ready;

    assign mag_x   = tkps_pkg::offset_mag(req.offset_x);
    assign mag_y   = tkps_pkg::offset_mag(req.offset_y);
    assign sq_x    = mag_x * mag_x;
    assign sq_y    = mag_y * mag_y;
    assign dist_sq = tkps_pkg::DIST_W'(sq_x) + tkps_pkg::DIST_W'(sq_y);

    // The stage drains whenever the chain is not busy, which is exactly when
    // a new transaction can be accepted.
    always_comb
    begin
        priority if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (!hold)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg            <= req.operation;
            entry_reg.x       <= req.pos_x;
            entry_reg.y       <= req.pos_y;
            entry_reg.vis     <= req.visible;
            entry_reg.dist_sq <= dist_sq;
        end
    end

    assign stage = '{valid: valid_reg, op: op_reg, entry: entry_reg};

endmodule

// File: rtl/tkps_cell.sv
// One slot of the sorted chain: holds an entry, takes the newcomer or its
// upper neighbor on an offer, and takes its lower neighbor on a drain shift.
// Depends on tkps_pkg.
`timescale 1ns / 1ps

module tkps_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tkps_pkg::cell_ctrl_t  ctrl,
    input  tkps_pkg::entry_t      new_entry,
    input  tkps_pkg::entry_t      prev_entry,
    input  logic                  prev_valid,
    input  logic                  prev_better,
    input  tkps_pkg::entry_t      next_entry,
    input  logic                  next_valid,
    output tkps_pkg::entry_t      entry,
    output logic                  valid,
    output logic                  better
);

    tkps_pkg::entry_t entry_reg;
    tkps_pkg::entry_t entry_next;
    logic             valid_reg;
    logic             valid_next;

    // An empty slot loses to any candidate. Because the chain is sorted, the
    // newcomer lands in the first slot it beats whose upper neighbor it does not.
    assign better = !valid_reg || tkps_pkg::beats(new_entry, entry_reg);

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        priority if (ctrl.shift)
        begin
            entry_next = next_entry;
            valid_next = next_valid;
        end
        else if (ctrl.offer && better)
        begin
            entry_next = prev_better ? prev_entry : new_entry;
            valid_next = valid_reg || prev_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

// File: rtl/top_k_priority_selector.sv
// Path: an offer goes through the distance stage register into the chain cells; a
// flush of a non-empty chain sends its entries through the output register, one per
// cycle while the receiver is ready. Throughput: one offer per cycle while no drain
// holds the input, set by the single compare in each chain cell.
// Reset clears the stage and cell valid bits, the drain state and the output valid
// bit; entry payloads are left undefined and are never read before they are written.
`timescale 1ns / 1ps

module top_k_priority_selector
(
    input  logic       clk,
    input  logic       rst_n,
    tkps_in_if.sink    req,
    tkps_out_if.source rsp
);

    localparam int CAP = tkps_pkg::CAPACITY;

    tkps_pkg::stage_t      stage;
    tkps_pkg::cell_ctrl_t  ctrl;
    tkps_pkg::state_t      state_reg;
    tkps_pkg::state_t      state_next;

    tkps_pkg::entry_t      cell_entry  [CAP];
    tkps_pkg::entry_t      prev_entry  [CAP];
    tkps_pkg::entry_t      next_entry  [CAP];
    logic [CAP-1:0]        cell_valid;
    logic [CAP-1:0]        cell_better;
    logic [CAP-1:0]        prev_valid;
    logic [CAP-1:0]        prev_better;
    logic [CAP-1:0]        next_valid;

    tkps_pkg::entry_t      out_reg;
    logic                  out_last_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  hold;
    logic                  last_now;
    logic [tkps_pkg::DIST_W+tkps_pkg::OUT_DIST_W-1:0] dist_wide;

    tkps_dist u_dist
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .hold  (hold),
        .stage (stage)
    );

    genvar i;
    generate
        for (i = 0; i < CAP; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                assign prev_entry[i]  = stage.entry;
                assign prev_valid[i]  = 1'b1;
                assign prev_better[i] = 1'b0;
            end
            else
            begin : g_body
                assign prev_entry[i]  = cell_entry[i-1];
                assign prev_valid[i]  = cell_valid[i-1];
                assign prev_better[i] = cell_better[i-1];
            end

            if (i == CAP - 1)
            begin : g_tail
                assign next_entry[i] = stage.entry;
                assign next_valid[i] = 1'b0;
            end
            else
            begin : g_link
                assign next_entry[i] = cell_entry[i+1];
                assign next_valid[i] = cell_valid[i+1];
            end

            tkps_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .new_entry   (stage.entry),
                .prev_entry  (prev_entry[i]),
                .prev_valid  (prev_valid[i]),
                .prev_better (prev_better[i]),
                .next_entry  (next_entry[i]),
                .next_valid  (next_valid[i]),
                .entry       (cell_entry[i]),
                .valid       (cell_valid[i]),
                .better      (cell_better[i])
            );
        end
    endgenerate

    // The head entry is the final one of a drain when nothing stands behind it.
    assign last_now = !next_valid[0];

    always_comb
    begin
        state_next     = state_reg;
        hold           = 1'b0;
        ctrl.offer     = 1'b0;
        ctrl.shift     = 1'b0;
        unique case (state_reg)
            tkps_pkg::ST_COLLECT:
            begin
                ctrl.offer = stage.valid && (stage.op == tkps_pkg::OP_OFFER);
                if (stage.valid && (stage.op == tkps_pkg::OP_FLUSH) && cell_valid[0])
                begin
                    state_next = tkps_pkg::ST_DRAIN;
                end
            end
            tkps_pkg::ST_DRAIN:
            begin
                hold       = 1'b1;
                ctrl.shift = !out_valid_reg || rsp.ready;
                if (ctrl.shift && last_now)
                begin
                    state_next = tkps_pkg::ST_COLLECT;
                end
            end
            default:
            begin
                state_next = tkps_pkg::ST_COLLECT;
            end
        endcase

        priority if (ctrl.shift)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tkps_pkg::ST_COLLECT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            out_reg      <= cell_entry[0];
            out_last_reg <= last_now;
        end
    end

    assign dist_wide       = {tkps_pkg::OUT_DIST_W'(0), out_reg.dist_sq};
    assign rsp.valid       = out_valid_reg;
    assign rsp.out_x       = out_reg.x;
    assign rsp.out_y       = out_reg.y;
    assign rsp.out_visible = out_reg.vis;
    assign rsp.out_dist_sq = dist_wide[tkps_pkg::OUT_DIST_W-1:0];
    assign rsp.last        = out_last_reg;

    // Held entries always fill the chain from the head with no gaps.
    a_valid_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid & (cell_valid + CAP'(1))) == '0)
        else $error("chain valid bits are not contiguous from the head");

    // The shift that emits the final entry leaves the chain empty.
    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.shift && last_now) |=> (cell_valid == '0))
        else $error("chain not empty after the final drained entry");

    // No offer reaches the chain while it is draining.
    a_no_offer_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tkps_pkg::ST_DRAIN) |-> !ctrl.offer)
        else $error("offer applied to the chain during a drain");

    generate
        for (i = 1; i < CAP; i++)
        begin : g_order_chk
            // No held entry ranks strictly ahead of the one above it.
            a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
                cell_valid[i] |-> !tkps_pkg::beats(cell_entry[i], cell_entry[i-1]))
                else $error("chain entries out of order");
        end
    endgenerate

endmodule

// File: dv/tb.sv
// Self-checking testbench for top_k_priority_selector: random bursty offers and flushes,
// with a shadow ranking of the held candidates that predicts every flushed entry.
// Depends on tkps_pkg, tkps_if and the top_k_priority_selector RTL.
`timescale 1ns / 1ps

module tb;

    localparam int TARGET_ITEMS = 410;
    localparam int DRAIN_WAIT   = 12;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct
    {
        tkps_pkg::op_t                op;
        logic [tkps_pkg::COORD_W-1:0] px;
        logic [tkps_pkg::COORD_W-1:0] py;
        logic [tkps_pkg::OFS_W-1:0]   ox;
        logic [tkps_pkg::OFS_W-1:0]   oy;
        logic                         vis;
    } scan_item_t;

    typedef struct
    {
        logic [tkps_pkg::COORD_W-1:0]    x;
        logic [tkps_pkg::COORD_W-1:0]    y;
        logic                            vis;
        logic [tkps_pkg::OUT_DIST_W-1:0] dist_sq;
        logic                            last;
    } pick_t;

    logic clk;
    logic rst_n;

    tkps_in_if  in_ch ();
    tkps_out_if out_ch ();

    top_k_priority_selector uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (in_ch),
        .rsp   (out_ch)
    );

    scan_item_t feed[$];
    pick_t      expected_picks[$];

    // Shadow copy of the ranked buffer, best entry at index 0.
    logic [tkps_pkg::COORD_W-1:0] held_x[tkps_pkg::CAPACITY];
    logic [tkps_pkg::COORD_W-1:0] held_y[tkps_pkg::CAPACITY];
    logic                         held_vis[tkps_pkg::CAPACITY];
    longint                       held_dist[tkps_pkg::CAPACITY];
    int                           held_count;

    int          mismatches;
    int          offers_seen;
    int          flushes_seen;
    int          results_seen;
    int          burst_left;
    int          gap_left;
    logic [31:0] cycle_count;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (mismatches < 40)
        begin
            $display("MISMATCH at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want);
        end
        mismatches++;
    endtask

    function automatic int clamp_offset(logic signed [tkps_pkg::OFS_W-1:0] ofs);
        int v;
        v = ofs;
        if (v > tkps_pkg::MAX_RADIUS)
        begin
            v = tkps_pkg::MAX_RADIUS;
        end
        else if (v < -tkps_pkg::MAX_RADIUS)
        begin
            v = -tkps_pkg::MAX_RADIUS;
        end
        return v;
    endfunction

    function automatic logic outranks(logic vis, longint dist_sq, int idx);
        if (vis != held_vis[idx])
        begin
            return vis;
        end
        return dist_sq < held_dist[idx];
    endfunction

    // Updates the shadow buffer for one accepted transaction; a flush queues its entries.
    function automatic void predict_selection(scan_item_t it);
        int     dx;
        int     dy;
        longint dist_sq;
        int     at;
        pick_t  p;
        if (it.op == tkps_pkg::OP_FLUSH)
        begin
            for (int i = 0; i < held_count; i++)
            begin
                p.x       = held_x[i];
                p.y       = held_y[i];
                p.vis     = held_vis[i];
                p.dist_sq = held_dist[i][tkps_pkg::OUT_DIST_W-1:0];
                p.last    = (i == held_count - 1);
                expected_picks = {expected_picks, p};
            end
            held_count = 0;
            return;
        end
        dx      = clamp_offset(it.ox);
        dy      = clamp_offset(it.oy);
        dist_sq = longint'(dx) * dx + longint'(dy) * dy;
        if (held_count < tkps_pkg::CAPACITY)
        begin
            at = held_count;
            held_count++;
        end
        else
        begin
            // A full buffer only admits a strictly better newcomer.
            at = tkps_pkg::CAPACITY - 1;
            if (!outranks(it.vis, dist_sq, at))
            begin
                return;
            end
        end
        while (at > 0 && outranks(it.vis, dist_sq, at - 1))
        begin
            held_x[at]    = held_x[at - 1];
            held_y[at]    = held_y[at - 1];
            held_vis[at]  = held_vis[at - 1];
            held_dist[at] = held_dist[at - 1];
            at--;
        end
        held_x[at]    = it.px;
        held_y[at]    = it.py;
        held_vis[at]  = it.vis;
        held_dist[at] = dist_sq;
    endfunction

    function automatic void queue_offer(logic [31:0] px, logic [31:0] py, int ox, int oy,
                                        logic vis);
        scan_item_t it;
        it.op  = tkps_pkg::OP_OFFER;
        it.px  = px;
        it.py  = py;
        it.ox  = tkps_pkg::OFS_W'(ox);
        it.oy  = tkps_pkg::OFS_W'(oy);
        it.vis = vis;
        feed = {feed, it};
    endfunction

    // Payload fields of a flush are don't-care, so they carry random noise.
    function automatic void queue_flush();
        scan_item_t it;
        it.op  = tkps_pkg::OP_FLUSH;
        it.px  = $urandom();
        it.py  = $urandom();
        it.ox  = tkps_pkg::OFS_W'($urandom());
        it.oy  = tkps_pkg::OFS_W'($urandom());
        it.vis = 1'($urandom());
        feed = {feed, it};
    endfunction

    function automatic int pick_offset(int mode);
        int v;
        case (mode)
            0: v = $urandom_range(0, 2047);
            1: v = int'($urandom_range(0, 6)) - 3;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: v = -1024;
                    1: v = -1023;
                    2: v = 1023;
                    default: v = 0;
                endcase
            end
            default: v = int'($urandom_range(0, 200)) - 100;
        endcase
        return v;
    endfunction

    // Driver: bursts of back-to-back transactions separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin : driver
        scan_item_t it;
        if (!rst_n)
        begin
            in_ch.valid     <= 1'b0;
            in_ch.operation <= tkps_pkg::OP_OFFER;
            in_ch.pos_x     <= '0;
            in_ch.pos_y     <= '0;
            in_ch.offset_x  <= '0;
            in_ch.offset_y  <= '0;
            in_ch.visible   <= 1'b0;
            burst_left      <= 0;
            gap_left        <= 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (gap_left != 0)
            begin
                gap_left    <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end
            else if (feed.size() != 0)
            begin
                it = feed.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.operation <= it.op;
                in_ch.pos_x     <= it.px;
                in_ch.pos_y     <= it.py;
                in_ch.offset_x  <= it.ox;
                in_ch.offset_y  <= it.oy;
                in_ch.visible   <= it.vis;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: the stall pattern is chosen by bits 9:8 of the cycle counter.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            case (cycle_count[9:8])
                2'd0: out_ch.ready <= 1'b1;
                2'd1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                2'd2: out_ch.ready <= (cycle_count[2:0] != 3'd5) && (cycle_count[2:0] != 3'd6);
                default: out_ch.ready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    // Monitor: results are checked before the same edge's input is predicted.
    always @(posedge clk)
    begin : monitor
        pick_t      want;
        scan_item_t seen;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                if (expected_picks.size() == 0)
                begin
                    report_mismatch("result with nothing pending, out_x", out_ch.out_x, 0);
                end
                else
                begin
                    want = expected_picks.pop_front();
                    if (out_ch.out_x !== want.x)
                        report_mismatch("out_x", out_ch.out_x, want.x);
                    if (out_ch.out_y !== want.y)
                        report_mismatch("out_y", out_ch.out_y, want.y);
                    if (out_ch.out_visible !== want.vis)
                        report_mismatch("out_visible", out_ch.out_visible, want.vis);
                    if (out_ch.out_dist_sq !== want.dist_sq)
                        report_mismatch("out_dist_sq", out_ch.out_dist_sq, want.dist_sq);
                    if (out_ch.last !== want.last)
                        report_mismatch("last", out_ch.last, want.last);
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                seen.op  = in_ch.operation;
                seen.px  = in_ch.pos_x;
                seen.py  = in_ch.pos_y;
                seen.ox  = in_ch.offset_x;
                seen.oy  = in_ch.offset_y;
                seen.vis = in_ch.visible;
                if (seen.op == tkps_pkg::OP_FLUSH)
                    flushes_seen++;
                else
                    offers_seen++;
                predict_selection(seen);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out with %0d results still pending.", expected_picks.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus
        int total;
        int burst;
        int mode;
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.operation = tkps_pkg::OP_OFFER;
        in_ch.pos_x     = '0;
        in_ch.pos_y     = '0;
        in_ch.offset_x  = '0;
        in_ch.offset_y  = '0;
        in_ch.visible   = 1'b0;
        out_ch.ready    = 1'b0;
        cycle_count     = '0;
        held_count      = 0;
        mismatches      = 0;
        offers_seen     = 0;
        flushes_seen    = 0;
        results_seen    = 0;

        // Empty flush, then a single entry at the coordinate and offset extremes.
        queue_flush();
        queue_offer(32'h7FFF_FFFF, 32'h8000_0000, 1023, -1024, 1'b0);
        queue_flush();
        // Ties keep arrival order, invisible ranks behind, full buffer needs strictly better.
        queue_offer(32'h0000_0001, 32'h0000_0002, 3, 4, 1'b1);
        queue_offer(32'h0000_0003, 32'h0000_0004, -4, 3, 1'b1);
        queue_offer(32'hFFFF_FFFF, 32'h0000_0000, 0, 0, 1'b0);
        queue_offer(32'h1234_5678, 32'h9ABC_DEF0, 0, -1, 1'b1);
        queue_offer(32'h0000_0005, 32'h0000_0006, 1, 0, 1'b0);
        queue_offer(32'h0000_0007, 32'h0000_0008, 0, 0, 1'b0);
        queue_offer(32'h0000_0009, 32'h0000_000A, 5, 5, 1'b1);
        queue_offer(32'h0000_000B, 32'h0000_000C, -5, -5, 1'b1);
        queue_offer(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 1'b1);
        queue_flush();
        queue_flush();
        // Saturation on both axes and the largest distances.
        queue_offer(32'hFFFF_FFFF, 32'h0000_0000, -1023, 1023, 1'b1);
        queue_offer(32'h0000_0000, 32'hFFFF_FFFF, -1024, -1024, 1'b1);
        queue_offer(32'h5555_5555, 32'hAAAA_AAAA, 1023, 1023, 1'b0);
        queue_offer(32'hAAAA_AAAA, 32'h5555_5555, -1024, 0, 1'b0);
        queue_offer(32'h0F0F_0F0F, 32'hF0F0_F0F0, 0, -1024, 1'b1);
        queue_flush();

        total = feed.size();
        while (total < TARGET_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                queue_flush();
                total++;
            end
            else
            begin
                burst = $urandom_range(1, 10);
                mode  = $urandom_range(0, 3);
                repeat (burst)
                begin
                    queue_offer($urandom(), $urandom(), pick_offset(mode), pick_offset(mode),
                                1'($urandom()));
                end
                queue_flush();
                total += burst + 1;
            end
        end
        queue_flush();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (feed.size() != 0 || in_ch.valid)
            @(posedge clk);
        while (expected_picks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d offers and %0d flushes; %0d ranked entries were compared.",
                 offers_seen, flushes_seen, results_seen);
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("%0d mismatches found.", mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
